>>> hdl/slsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slsi_pkg;

  // Number of values the store can hold.
  localparam int CAPACITY = 64;

  // Width of the internal occupancy count, wide enough to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Fixed field widths of the item interface.
  localparam int VAL_W = 32;
  localparam int OUT_CNT_W = 7;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic [OUT_CNT_W-1:0]     count;
    logic signed [VAL_W-1:0]  smallest;
  } out_item_t;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic                     en;
    kind_t                    kind;
    logic signed [VAL_W-1:0]  value;
  } bcast_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic                     vld;
    logic                     sel;
    logic signed [VAL_W-1:0]  value;
  } nbr_t;

endpackage

`default_nettype wire

>>> hdl/slsi_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module slsi_cell
  import slsi_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire bcast_t op,
  input  wire nbr_t   left,
  input  wire nbr_t   right,
  output nbr_t        self,
  output logic        match
);

  logic                    vld_r;
  logic                    vld_nxt;
  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;
  logic                    ge;
  logic                    sel;

  // The list is sorted, so the cells at or after the operation point form
  // a suffix and each cell can decide locally whether it moves.
  assign ge    = (value_r >= op.value);
  assign sel   = (op.kind == KIND_INSERT) ? (!vld_r || ge) : (vld_r && ge);
  assign match = vld_r && (value_r == op.value);

  always_comb begin
    value_nxt = value_r;
    vld_nxt   = vld_r;
    if (op.en) begin
      unique case (op.kind)
        KIND_INSERT: begin
          vld_nxt = vld_r | left.vld;
          if (sel) begin
            value_nxt = left.sel ? left.value : op.value;
          end
        end
        KIND_DELETE: begin
          if (sel) begin
            value_nxt = right.value;
            vld_nxt   = right.vld;
          end
        end
        default: begin
          value_nxt = value_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign self.vld   = vld_r;
  assign self.sel   = sel;
  assign self.value = value_r;

endmodule

`default_nettype wire

>>> hdl/sorted_list_insert_delete_top.sv
// Sorted value store: holds up to CAPACITY signed 32-bit values in ascending
// order in a row of cells, one value per cell. Every item is broadcast to all
// cells at once; each cell compares its value with the item's and either keeps
// it or takes its neighbor's, so an insert opens a gap in front of the first
// value that is not smaller and a delete closes the gap left by the first
// matching copy. The block accepts one item per clock cycle whenever the
// output register is empty or being emptied, and delivers its result in the
// cycle after acceptance; throughput is limited only by the result channel.
// Each result carries the status, the count after the item and the head value
// (zero when the list is empty). An insert into a full store is dropped with
// status full; a delete from an empty store reports empty, and a delete of an
// absent value reports not found. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_delete_top
  import slsi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  nbr_t                    cell_w [0:CAPACITY];
  logic [CAPACITY-1:0]     match_vec;
  logic [CAPACITY-1:0]     vld_vec;
  bcast_t                  op;
  logic                    accept;
  logic                    found;
  logic                    full;
  logic                    empty;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  status_t                 status;
  logic signed [VAL_W-1:0] head_nxt;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  // The output register is the only stage; a new item may enter in the same
  // cycle the previous result is taken.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);
  assign found = |match_vec;

  always_comb begin
    count_nxt = count_r;
    status    = ST_DONE;
    unique case (in_item.kind)
      KIND_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_DELETE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  // Cells only move when the item really changes the contents.
  assign op.en    = accept && (status == ST_DONE);
  assign op.kind  = in_item.kind;
  assign op.value = in_item.value;

  // Past the last cell sits an always-empty slot, so a delete shifts in
  // an invalid entry at the tail.
  assign cell_w[CAPACITY].vld   = 1'b0;
  assign cell_w[CAPACITY].sel   = 1'b0;
  assign cell_w[CAPACITY].value = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    nbr_t left;
    if (i == 0) begin : g_head
      // The head has nothing to its left: an insert there takes the item value.
      assign left.vld   = 1'b1;
      assign left.sel   = 1'b0;
      assign left.value = '0;
    end else begin : g_body
      assign left = cell_w[i-1];
    end

    slsi_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (op),
      .left  (left),
      .right (cell_w[i+1]),
      .self  (cell_w[i]),
      .match (match_vec[i])
    );

    assign vld_vec[i] = cell_w[i].vld;
  end

  // Head value after the item, worked out from the head cell and its
  // right neighbor without waiting for the cells to update.
  always_comb begin
    head_nxt = cell_w[0].vld ? cell_w[0].value : '0;
    if (op.en) begin
      if (op.kind == KIND_INSERT) begin
        head_nxt = cell_w[0].sel ? op.value : cell_w[0].value;
      end else if (cell_w[0].sel) begin
        head_nxt = cell_w[1].vld ? cell_w[1].value : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r.status   <= status;
      out_item_r.count    <= OUT_CNT_W'(count_nxt);
      out_item_r.smallest <= head_nxt;
    end
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The occupied cells always form a prefix whose length is the count.
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == count_r)
    else $error("cell occupancy disagrees with count");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    vld_vec[0] == !empty)
    else $error("head cell occupancy disagrees with count");

  a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.kind == KIND_INSERT) && full |=>
      (out_item.status == ST_FULL) && full)
    else $error("insert into full store was not dropped");

  a_found_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.kind == KIND_DELETE) && found |=>
      (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete of a stored value did not shrink the count");

endmodule

`default_nettype wire

>>> test/slsi_tb_pkg.sv
`timescale 1ns / 1ps

package slsi_tb_pkg;
  import slsi_pkg::*;

  class sorted_store_tracker;
    // Mirror of the stored values, kept in ascending signed order.
    logic signed [VAL_W-1:0] mirror_values[$];
    // Results owed by the block, oldest first.
    out_item_t awaited_results[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Applies one accepted item to the mirror and queues the result it must produce.
    function void note_item(in_item_t item);
      out_item_t res;
      logic signed [VAL_W-1:0] v;
      int pos;
      v = item.value;
      pos = 0;
      if (item.kind == KIND_INSERT) begin
        if (mirror_values.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // An equal value goes ahead of the copies already stored.
          while (pos < mirror_values.size() && mirror_values[pos] < v) pos++;
          mirror_values.insert(pos, v);
          res.status = ST_DONE;
        end
      end else if (mirror_values.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        while (pos < mirror_values.size() && mirror_values[pos] != v) pos++;
        if (pos == mirror_values.size()) begin
          res.status = ST_NOT_FOUND;
        end else begin
          mirror_values.delete(pos);
          res.status = ST_DONE;
        end
      end
      res.count = OUT_CNT_W'(mirror_values.size());
      res.smallest = (mirror_values.size() > 0) ? mirror_values[0] : '0;
      awaited_results.push_back(res);
    endfunction

    // Compares one accepted result with the oldest one owed.
    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d count %0d smallest %0d",
                 $time, got.status, got.count, got.smallest);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        mismatches++;
      end
      if (got.smallest !== want.smallest) begin
        $display("%0t: smallest expected %0d actual %0d", $time, want.smallest,
                 got.smallest);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // A value currently held, so that deletes hit and inserts make duplicates.
    function logic signed [VAL_W-1:0] pick_stored();
      if (mirror_values.size() == 0) return $urandom;
      return mirror_values[$urandom_range(0, mirror_values.size() - 1)];
    endfunction
  endclass

endpackage

>>> test/sorted_list_insert_delete_top_tb.sv
`timescale 1ns / 1ps

module sorted_list_insert_delete_top_tb;
  import slsi_pkg::*;
  import slsi_tb_pkg::*;

  // With both sides idling at their longest, this still leaves plenty of
  // margin for about 1850 items.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int MAX_GAP = 14;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  sorted_store_tracker tracker = new();

  // When set, the corresponding side runs without idle cycles.
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  // A one-shot request for the receiver to stall this many cycles.
  int recv_hold = 0;
  int unsigned cycle_count = 0;

  sorted_list_insert_delete_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Both handshakes are observed at the rising edge. Inputs only change at the
  // falling edge, so the values seen here are the ones the block samples.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_item(in_item);
      if (out_valid && out_ready) tracker.check_result(out_item);
    end
  end

  // Hard stop in case the block hangs on either channel.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_list_insert_delete_top regression: fail");
    $finish;
  end

  // Receiver: before each result it stalls a random number of cycles, unless
  // a long hold has been requested, in which case it counts that out here.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (recv_hold > 0) begin
        stall = recv_hold;
        recv_hold = 0;
      end else begin
        stall = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic in_item_t op(kind_t kind, logic signed [VAL_W-1:0] value);
    in_item_t item;
    item.kind = kind;
    item.value = value;
    return item;
  endfunction

  // Offers one item after a random gap and returns at the falling edge after it
  // has been accepted. Must be entered at a falling edge. Valid is only lowered
  // when a gap follows, so it never gets two updates in one time step.
  task automatic send_item(in_item_t item);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() > 0) @(negedge clk);
  endtask

  // Random item. Values mix full-range noise, a narrow band around zero that
  // produces many duplicates, the extremes of the signed range, and values
  // currently stored so that deletes can find their target.
  function automatic in_item_t make_item(int insert_pct);
    in_item_t item;
    int pick;
    item.kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      item.value = $urandom;
    end else if (pick < 5) begin
      item.value = $urandom_range(0, 16) - 8;
    end else if (pick < 6) begin
      case ($urandom_range(0, 3))
        0: item.value = 32'h8000_0000;
        1: item.value = 32'h7fff_ffff;
        2: item.value = 32'h8000_0001;
        default: item.value = 32'h7fff_fffe;
      endcase
    end else begin
      item.value = tracker.pick_stored();
    end
    return item;
  endfunction

  initial begin
    int phase;
    int phase_len;
    int insert_pct;
    int random_sent;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. A delete into the empty store reports empty; then the
    // signed extremes and their neighbors are inserted to check that ordering
    // is two's complement, a duplicate zero is added, and everything is taken
    // out again, including a miss, head changes and a final delete on empty.
    send_item(op(KIND_DELETE, 32'sd5));
    send_item(op(KIND_INSERT, 32'sd0));
    send_item(op(KIND_INSERT, 32'h8000_0000));
    send_item(op(KIND_INSERT, 32'h7fff_ffff));
    send_item(op(KIND_INSERT, -32'sd1));
    send_item(op(KIND_INSERT, 32'sd1));
    send_item(op(KIND_INSERT, 32'sd0));
    send_item(op(KIND_INSERT, 32'h8000_0001));
    send_item(op(KIND_INSERT, 32'h7fff_fffe));
    send_item(op(KIND_DELETE, 32'sd0));
    send_item(op(KIND_DELETE, 32'sd7));
    send_item(op(KIND_DELETE, 32'h8000_0000));
    send_item(op(KIND_DELETE, 32'h8000_0001));
    send_item(op(KIND_DELETE, 32'h7fff_ffff));
    send_item(op(KIND_INSERT, 32'h7fff_ffff));
    send_item(op(KIND_DELETE, 32'sd0));
    send_item(op(KIND_DELETE, -32'sd1));
    send_item(op(KIND_DELETE, 32'sd1));
    send_item(op(KIND_DELETE, 32'h7fff_fffe));
    send_item(op(KIND_DELETE, 32'h7fff_ffff));
    send_item(op(KIND_DELETE, 32'h7fff_ffff));
    wait_for_results();

    // Random part in phases. The first phase is insert-heavy and runs the
    // store into full so that dropped inserts occur; the second holds the
    // receiver off for a long stretch while the sender keeps pushing with no
    // gaps, which fills the output stage and stalls the input; the third is
    // delete-heavy and drains the store to empty. After that the mix and the
    // idling of both sides are drawn per phase. Every third phase ends with
    // the sender pausing until all results are back.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      case (phase)
        0: begin
          insert_pct = 95;
          phase_len = 120;
        end
        1: begin
          insert_pct = 50;
          phase_len = 100;
          send_quiet = 1'b1;
          recv_hold = LONG_HOLD;
        end
        2: begin
          insert_pct = 10;
          phase_len = 150;
        end
        default: begin
          case ($urandom_range(0, 2))
            0: insert_pct = 25;
            1: insert_pct = 50;
            default: insert_pct = 80;
          endcase
          phase_len = $urandom_range(40, 160);
        end
      endcase
      repeat (phase_len) begin
        send_item(make_item(insert_pct));
        random_sent++;
      end
      if (phase % 3 == 2) wait_for_results();
      phase++;
    end

    wait_for_results();
    // The block answers in the cycle after acceptance; the bench idles on in case
    // anything stray comes out.
    repeat (10) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("sorted_list_insert_delete_top regression: pass");
    end else begin
      $display("sorted_list_insert_delete_top regression: fail");
    end
    $finish;
  end

endmodule
